// File: rtl/core/qkc_pkg.sv
// Shared types and constants for the quadrature knob counter.
package qkc_pkg;

   // Width of one configuration word and of the knob value
   localparam int unsigned VALUE_W = 8;
   // Width of the configuration register index
   localparam int unsigned CSR_INDEX_W = 8;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_VALUE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VALUE = 8'd1;

   // Reset values of the limits
   localparam logic signed [VALUE_W-1:0] MIN_VALUE_RESET = 8'sd0;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE_RESET = 8'sd7;

   // Direction table, indexed by {previous phase, current phase}.
   // The phase state is {phase_b, phase_a}.
   localparam logic signed [1:0] DIR_TABLE [16] = '{
      2'sd0,  2'sd1,  -2'sd1, 2'sd0,
      -2'sd1, 2'sd0,  2'sd0,  2'sd1,
      2'sd1,  2'sd0,  2'sd0,  -2'sd1,
      2'sd0,  -2'sd1, 2'sd1,  2'sd0
   };

   // Signed type of the knob value and of its limits
   typedef logic signed [VALUE_W-1:0] value_type;

endpackage

// File: rtl/core/quadrature_knob_counter.sv
// Quadrature knob counter: phase samples in, debounced knob value out.
//
// Each input word carries one sample of the encoder lines A and B. The
// block takes one word every clock while the result stream is not stalled;
// an accepted word passes through the input register and then the update
// stage, which looks up the direction table, adds to the step accumulator,
// compares against the threshold and the limits, and loads the result
// register. The rate is set by that single update stage, which closes the
// loop on the accumulator and the knob value. Every sample gives exactly
// one result word. The knob value moves by one for every STEP_THRESHOLD
// net steps in one direction, and stays within min_value and max_value.
// Write the limits only while no sample is in flight; a limit write waits
// while a sample sits in the input register, and a write clamps the knob
// value into the new range at once.
module quadrature_knob_counter #(
   parameter int STEP_THRESHOLD = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   // Sample stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] phase_a, [1] phase_b
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [7:0] knob_value, [8] changed
   // Configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qkc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qkc_pkg::VALUE_W-1:0]       csr_data
);

   // Accumulator holds -STEP_THRESHOLD..STEP_THRESHOLD
   localparam int ACC_W = $clog2(STEP_THRESHOLD + 1) + 1;
   localparam logic signed [ACC_W-1:0] THR      = ACC_W'(STEP_THRESHOLD);
   localparam logic signed [ACC_W-1:0] NEG_THR  = ACC_W'(-STEP_THRESHOLD);
   localparam logic signed [ACC_W-1:0] HOLD_POS = ACC_W'(STEP_THRESHOLD - 1);
   localparam logic signed [ACC_W-1:0] HOLD_NEG = ACC_W'(1 - STEP_THRESHOLD);

   // Input register
   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_phase_ff, s1_phase_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   qkc_pkg::value_type      rsp_value_ff, rsp_value_in;
   logic                    rsp_changed_ff, rsp_changed_in;

   // Block state
   logic [1:0]              last_phase_ff, last_phase_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   qkc_pkg::value_type      value_ff, value_in;
   qkc_pkg::value_type      min_ff, min_in;
   qkc_pkg::value_type      max_ff, max_in;

   // Handshake and datapath helpers
   logic                    s2_ready;
   logic                    s2_fire;
   logic                    req_fire;
   logic                    csr_fire;
   logic signed [1:0]       dir;
   logic signed [ACC_W-1:0] sum;
   logic signed [8:0]       inc_value;
   logic signed [8:0]       dec_value;
   logic                    step_moved;
   logic signed [ACC_W-1:0] step_acc;
   qkc_pkg::value_type      step_value;
   qkc_pkg::value_type      clamp_min;
   qkc_pkg::value_type      clamp_max;
   qkc_pkg::value_type      clamp_low;
   qkc_pkg::value_type      clamp_value;

   // Pipeline handshake: the result register frees the update stage
   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s2_fire    = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;
   // Hold off limit writes while a sample waits for the update stage
   assign csr_ready  = !s1_valid_ff;
   assign csr_fire   = csr_valid && csr_ready;

   // Load the input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_phase_in = s1_phase_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_phase_in = req_tdata[1:0];
      end else if (s2_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Look up the direction and add it to the accumulator
   assign dir       = qkc_pkg::DIR_TABLE[{last_phase_ff, s1_phase_ff}];
   assign sum       = acc_ff + ACC_W'(dir);
   assign inc_value = 9'(value_ff) + 9'sd1;
   assign dec_value = 9'(value_ff) - 9'sd1;

   // Step the knob value at the threshold, hold the accumulator at a limit
   always_comb begin
      step_moved = 1'b0;
      step_acc   = acc_ff;
      step_value = value_ff;
      if (dir != 2'sd0) begin
         step_acc = sum;
         if (sum >= THR) begin
            if (inc_value <= 9'(max_ff)) begin
               step_value = inc_value[7:0];
               step_acc   = sum - THR;
               step_moved = 1'b1;
            end else begin
               step_acc = HOLD_POS;
            end
         end else if (sum <= NEG_THR) begin
            if (dec_value >= 9'(min_ff)) begin
               step_value = dec_value[7:0];
               step_acc   = sum + THR;
               step_moved = 1'b1;
            end else begin
               step_acc = HOLD_NEG;
            end
         end
      end
   end

   // Clamp the value into the limits after a register write
   always_comb begin
      clamp_min = min_ff;
      clamp_max = max_ff;
      case (csr_index)
         qkc_pkg::REG_MIN_VALUE: clamp_min = csr_data;
         qkc_pkg::REG_MAX_VALUE: clamp_max = csr_data;
         default: ;
      endcase
      clamp_low   = (value_ff < clamp_min) ? clamp_min : value_ff;
      clamp_value = (clamp_low > clamp_max) ? clamp_max : clamp_low;
   end

   // Update the state from a sample or a register write
   always_comb begin
      last_phase_in = last_phase_ff;
      acc_in        = acc_ff;
      value_in      = value_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      if (s2_fire) begin
         last_phase_in = s1_phase_ff;
         acc_in        = step_acc;
         value_in      = step_value;
      end else if (csr_fire) begin
         case (csr_index)
            qkc_pkg::REG_MIN_VALUE: begin
               min_in   = csr_data;
               value_in = clamp_value;
            end
            qkc_pkg::REG_MAX_VALUE: begin
               max_in   = csr_data;
               value_in = clamp_value;
            end
            default: ;
         endcase
      end
   end

   // Load the result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_changed_in = rsp_changed_ff;
      if (s2_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = step_value;
         rsp_changed_in = step_moved;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_phase_ff <= 2'b00;
         acc_ff        <= '0;
         value_ff      <= '0;
         min_ff        <= qkc_pkg::MIN_VALUE_RESET;
         max_ff        <= qkc_pkg::MAX_VALUE_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_phase_ff <= last_phase_in;
         acc_ff        <= acc_in;
         value_ff      <= value_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_phase_ff    <= s1_phase_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_changed_ff, rsp_value_ff};

endmodule

// File: rtl/core/qkc_checker.sv
// Port-level checks for the quadrature knob counter, bound to the top level.
module qkc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [7:0]                        req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [15:0]                       rsp_tdata,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [qkc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input logic [qkc_pkg::VALUE_W-1:0]       csr_data
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // With the output empty, the pipeline must take a new sample
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("sample refused while no result word waits");

   // A stalled result word stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its payload
   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

endmodule

bind quadrature_knob_counter qkc_checker u_qkc_checker (.*);
